>>> rtl/laplacian_sharpen_3x3_stream_defines.svh
// ----------------------------------------------------------------------------
// laplacian sharpen assertion macros
// shared property forms for the checker of the sharpening stream
// ----------------------------------------------------------------------------
`ifndef LAPLACIAN_SHARPEN_3X3_STREAM_DEFINES_SVH
`define LAPLACIAN_SHARPEN_3X3_STREAM_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define LSH_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lsh check failed");

// consequent must hold in the cycle after the antecedent
`define LSH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lsh check failed");

`endif

>>> rtl/lsh_pkg.sv
// ----------------------------------------------------------------------------
// lsh_pkg
// shared types and constants of the laplacian sharpening stream
// ----------------------------------------------------------------------------
package lsh_pkg;

	localparam int PIX_W         = 8;
	localparam int ROW_W         = 12;
	localparam int CFG_W         = 12;
	localparam int CFG_IDX_W     = 1;
	localparam int LAP_W         = PIX_W + 4;
	localparam int DEF_MAX_WIDTH = 2048;
	localparam int RESET_WIDTH   = 640;
	localparam int RESET_HEIGHT  = 480;
	localparam int MIN_SIZE      = 3;

	// decoupling queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// queue status seen by front and back
	typedef struct packed {
		logic             empty;
		logic [LVL_W-1:0] level;
	} lsh_qstat_t;

endpackage

>>> rtl/lsh_queue.sv
// ----------------------------------------------------------------------------
// lsh_queue
// small register queue that decouples the front from the back
// ----------------------------------------------------------------------------
module lsh_queue import lsh_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output lsh_qstat_t       stat
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [LVL_W-1:0] level_q;

	assign rd_data    = slot_q[rd_ptr_q];
	assign stat.empty = (level_q == '0);
	assign stat.level = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			level_q <= level_q + LVL_W'(wr_en) - LVL_W'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

>>> rtl/lsh_front.sv
// ----------------------------------------------------------------------------
// lsh_front
// accepts pixels, tracks raster position, runs the line store, computes
// the cross laplacian and queues one entry per item below the top row
// ----------------------------------------------------------------------------
module lsh_front import lsh_pkg::*; #(
	parameter  int MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int CW        = $clog2(MAX_WIDTH),
	localparam int EW        = 2 + ROW_W + CW + PIX_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [PIX_W-1:0]     pixel_in,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	input  lsh_qstat_t           qstat,
	output logic                 q_push,
	output logic [EW-1:0]        q_data
);

	localparam int RST_W     = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
	localparam int RST_WLAST = RST_W - 1;

	// line store word: older row in the upper byte, previous row in the lower
	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] rd_q;

	logic             pf_valid_q;
	logic [CW-1:0]    wlast_q;
	logic [ROW_W-1:0] hlast_q;
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [PIX_W-1:0] left_q;

	logic             valid_s1;
	logic [PIX_W-1:0] down_s1;
	logic [PIX_W-1:0] center_s1;
	logic [PIX_W-1:0] up_s1;
	logic [PIX_W-1:0] left_s1;
	logic [CW-1:0]    col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             interior_s1;
	logic             last_col_s1;
	logic             last_row_s1;

	logic                    room;
	logic                    accept;
	logic                    prefetch;
	logic                    rd_en;
	logic [CW-1:0]           rd_addr;
	logic [CW-1:0]           c;
	logic [ROW_W-1:0]        r;
	logic                    last_col;
	logic                    last_row;
	logic [CW-1:0]           wlast_new;
	logic [ROW_W-1:0]        hlast_new;
	logic signed [LAP_W-1:0] lap;
	logic [PIX_W-1:0]        pix;

	// position, saturated to the current frame size
	assign c        = (col_q > wlast_q) ? wlast_q : col_q;
	assign r        = (row_q > hlast_q) ? hlast_q : row_q;
	assign last_col = (c == wlast_q);
	assign last_row = (r == hlast_q);

	// the entry now in s1 and the new one must both fit
	assign room     = ({1'b0, qstat.level} + (LVL_W + 1)'(valid_s1))
	                  < (LVL_W + 1)'(QUEUE_DEPTH);
	assign prefetch = !pf_valid_q;
	assign full     = prefetch || !room;
	assign accept   = push && !full;
	assign rd_en    = accept || prefetch;
	assign rd_addr  = prefetch ? c : (last_col ? '0 : c + CW'(1));

	always_comb begin
		if (cfg_data < CFG_W'(MIN_SIZE)) begin
			wlast_new = CW'(MIN_SIZE - 1);
		end else if ({20'd0, cfg_data} > 32'(MAX_WIDTH)) begin
			wlast_new = CW'(MAX_WIDTH - 1);
		end else begin
			wlast_new = CW'(cfg_data - CFG_W'(1));
		end
		if (cfg_data < CFG_W'(MIN_SIZE)) begin
			hlast_new = ROW_W'(MIN_SIZE - 1);
		end else begin
			hlast_new = ROW_W'(cfg_data - CFG_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pf_valid_q <= 1'b0;
			wlast_q    <= CW'(RST_WLAST);
			hlast_q    <= ROW_W'(RESET_HEIGHT - 1);
			col_q      <= '0;
			row_q      <= '0;
			left_q     <= '0;
			valid_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (cfg_we) begin
				pf_valid_q <= 1'b0;
				unique case (cfg_reg_t'(cfg_idx))
					REG_FRAME_WIDTH:  wlast_q <= wlast_new;
					REG_FRAME_HEIGHT: hlast_q <= hlast_new;
				endcase
			end else if (prefetch) begin
				pf_valid_q <= 1'b1;
			end
			if (accept) begin
				if (last_col) begin
					col_q  <= '0;
					row_q  <= last_row ? '0 : r + ROW_W'(1);
					left_q <= '0;
				end else begin
					col_q  <= c + CW'(1);
					row_q  <= r;
					left_q <= rd_q[PIX_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			line_mem[c] <= {rd_q[PIX_W-1:0], pixel_in};
		end
		if (rd_en) begin
			rd_q <= line_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			down_s1     <= pixel_in;
			center_s1   <= rd_q[PIX_W-1:0];
			up_s1       <= rd_q[2*PIX_W-1:PIX_W];
			left_s1     <= left_q;
			col_s1      <= c;
			row_s1      <= r;
			interior_s1 <= (r >= ROW_W'(2)) && (c != '0) && !last_col;
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
		end
	end

	// right neighbour is the word fetched at accept time, now in rd_q
	assign lap = $signed({2'b00, center_s1, 2'b00}) + $signed({4'b0000, center_s1})
	           - $signed({4'b0000, left_s1}) - $signed({4'b0000, rd_q[PIX_W-1:0]})
	           - $signed({4'b0000, up_s1}) - $signed({4'b0000, down_s1});

	always_comb begin
		if (!interior_s1 || lap[LAP_W-1]) begin
			pix = '0;
		end else if (lap[LAP_W-2:PIX_W] != '0) begin
			pix = '1;
		end else begin
			pix = lap[PIX_W-1:0];
		end
	end

	assign q_push = valid_s1 && (row_s1 != '0);
	assign q_data = {last_row_s1 && last_col_s1, last_row_s1,
	                 row_s1 - ROW_W'(1), col_s1, pix};

endmodule

>>> rtl/lsh_back.sv
// ----------------------------------------------------------------------------
// lsh_back
// drains queued entries into the output register, splitting last-row
// entries into the sharpened pixel and the zero border pixel below it
// ----------------------------------------------------------------------------
module lsh_back import lsh_pkg::*; #(
	parameter  int MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int CW        = $clog2(MAX_WIDTH),
	localparam int EW        = 2 + ROW_W + CW + PIX_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [EW-1:0]    q_data,
	input  lsh_qstat_t       qstat,
	output logic             q_pop,
	input  logic             pop,
	output logic             empty,
	output logic [PIX_W-1:0] pixel_out,
	output logic [ROW_W-1:0] out_row,
	output logic [CW-1:0]    out_col,
	output logic             frame_end
);

	logic             out_valid_q;
	logic             pend_q;
	logic             end_pend_q;
	logic [PIX_W-1:0] pix_q;
	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    col_q;
	logic             end_q;

	logic advance;

	assign advance = !out_valid_q || pop;
	assign q_pop   = advance && !pend_q && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
			end_pend_q  <= 1'b0;
		end else if (advance) begin
			if (pend_q) begin
				pend_q <= 1'b0;
			end else if (!qstat.empty) begin
				out_valid_q <= 1'b1;
				pend_q      <= q_data[EW-2];
				end_pend_q  <= q_data[EW-1];
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (pend_q) begin
				pix_q <= '0;
				row_q <= row_q + ROW_W'(1);
				end_q <= end_pend_q;
			end else if (!qstat.empty) begin
				pix_q <= q_data[PIX_W-1:0];
				col_q <= q_data[PIX_W+CW-1:PIX_W];
				row_q <= q_data[PIX_W+CW+ROW_W-1:PIX_W+CW];
				end_q <= 1'b0;
			end
		end
	end

	assign empty     = !out_valid_q;
	assign pixel_out = pix_q;
	assign out_row   = row_q;
	assign out_col   = col_q;
	assign frame_end = end_q;

endmodule

>>> rtl/laplacian_sharpen_3x3_stream.sv
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_stream
// streaming 3x3 cross laplacian sharpening of 8-bit grayscale frames
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// input     in         push / full            pixel_in
// result    out        empty / pop            pixel_out, out_row, out_col, frame_end
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item is taken per cycle while full is low; an item of the last frame row gives
// two results, so there the output port sets the pace
// a result is formed when the item in the row below is taken, and is registered
// in the s1 stage, then in a four entry queue, then in the output register
// after reset and after every config write the line store read port fetches the
// current column word before the next item is taken, with full held high
// no clearing pass: line store contents before the first frame are don't care
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_stream import lsh_pkg::*; #(
	parameter  int MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int CW        = $clog2(MAX_WIDTH),
	localparam int EW        = 2 + ROW_W + CW + PIX_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input side
	input  logic                 push,
	output logic                 full,
	input  logic [PIX_W-1:0]     pixel_in,
	// result side
	output logic                 empty,
	input  logic                 pop,
	output logic [PIX_W-1:0]     pixel_out,
	output logic [ROW_W-1:0]     out_row,
	output logic [CW-1:0]        out_col,
	output logic                 frame_end,
	// register writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic          q_push;
	logic [EW-1:0] q_wdata;
	logic          q_pop;
	logic [EW-1:0] q_rdata;
	lsh_qstat_t    qstat;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	// front: counters, line store, laplacian, one queue entry per item below the top row
	lsh_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.pixel_in (pixel_in),
		.cfg_we   (cfg_valid),
		.cfg_idx  (cfg_index),
		.cfg_data (cfg_data),
		.qstat    (qstat),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	// decoupling queue, lets the output stall until the queue fills without stopping the line store
	lsh_queue #(
		.WIDTH (EW)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.stat    (qstat)
	);

	// back: output register, splits last-row entries into two results
	lsh_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_data    (q_rdata),
		.qstat     (qstat),
		.q_pop     (q_pop),
		.pop       (pop),
		.empty     (empty),
		.pixel_out (pixel_out),
		.out_row   (out_row),
		.out_col   (out_col),
		.frame_end (frame_end)
	);

endmodule

>>> rtl/lsh_checker.sv
// ----------------------------------------------------------------------------
// lsh_checker
// port level checks of the sharpening stream, bound to the top level
// ----------------------------------------------------------------------------
`include "laplacian_sharpen_3x3_stream_defines.svh"

module lsh_checker import lsh_pkg::*; #(
	parameter  int MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int CW        = $clog2(MAX_WIDTH)
) (
	input logic             clk,
	input logic             arst_n,
	input logic             empty,
	input logic             pop,
	input logic [PIX_W-1:0] pixel_out,
	input logic [ROW_W-1:0] out_row,
	input logic [CW-1:0]    out_col,
	input logic             frame_end
);

	// top border row is always zero
	`LSH_ASSERT_SAME(a_top_row_zero, !empty && out_row == '0, pixel_out == '0)

	// left border column is always zero
	`LSH_ASSERT_SAME(a_left_col_zero, !empty && out_col == '0, pixel_out == '0)

	// frame end marks the bottom right border pixel
	`LSH_ASSERT_SAME(a_end_is_border, !empty && frame_end, pixel_out == '0 && out_col != '0)

	// a waiting result is not withdrawn
	`LSH_ASSERT_NEXT(a_result_held, !empty && !pop, !empty)

endmodule

bind laplacian_sharpen_3x3_stream lsh_checker #(.MAX_WIDTH(MAX_WIDTH)) u_lsh_checker (.*);
